@@ design/midpoint_ellipse_generator_macros.svh @@
// Assertion helpers shared by the ellipse generator modules.
// Both expect signals named clk and arst_n in the module that uses them.
`ifndef MIDPOINT_ELLIPSE_GENERATOR_MACROS_SVH
`define MIDPOINT_ELLIPSE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define MEG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MEG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/meg_pkg.sv @@
package meg_pkg;

	localparam int CENTER_W        = 10;
	localparam int X_W             = 11;
	localparam int COORD_W         = 12;
	localparam int DEC_W           = 48;
	localparam int CFG_IDX_W       = 2;
	localparam int RADIUS_BITS_DEF = 10;

	localparam int CENTER_X_RST = 320;
	localparam int CENTER_Y_RST = 240;
	localparam int RADIUS_X_RST = 100;
	localparam int RADIUS_Y_RST = 50;

	// Shift amounts applied to an accumulator operand.
	localparam logic [1:0] SH_X1 = 2'd0;
	localparam logic [1:0] SH_X4 = 2'd2;
	localparam logic [1:0] SH_X8 = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_RADIUS_X,
		CFG_RADIUS_Y
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_RX,
		ST_SQ_RY,
		ST_RS_A,
		ST_RS_B,
		ST_RS_C,
		ST_CMP_A,
		ST_CMP_B,
		ST_CMP_C,
		ST_SW_0,
		ST_SW_1,
		ST_SW_2,
		ST_SW_3,
		ST_SW_4,
		ST_SW_5,
		ST_EMIT,
		ST_UPD_1,
		ST_UPD_2
	} state_t;

	typedef enum logic [3:0] {
		MUL_RX,
		MUL_RY,
		MUL_RX2,
		MUL_RY2,
		MUL_PROD,
		MUL_XCUR,
		MUL_XINC,
		MUL_X2P1,
		MUL_YABS,
		MUL_YM1ABS
	} mul_sel_t;

	typedef enum logic [1:0] {
		SRC_PROD,
		SRC_RX2,
		SRC_RY2
	} src_sel_t;

	typedef enum logic [1:0] {
		DEC_HOLD,
		DEC_ADD,
		DEC_SUB,
		DEC_YSIGN
	} dec_op_t;

	typedef struct packed {
		mul_sel_t   mul_a;
		mul_sel_t   mul_b;
		dec_op_t    dec_op;
		src_sel_t   dec_src;
		logic [1:0] dec_shift;
		logic       dec_clr;
		logic       ld_rx2;
		logic       ld_ry2;
		logic       ld_t1;
		logic       snap;
		logic       x_clr;
		logic       x_inc;
		logic       y_ld;
		logic       y_dec;
		logic       out_ld;
		logic       out_last;
	} ctrl_t;

	typedef struct packed {
		logic lt;
		logic y_neg;
		logic y_zero;
		logic dec_neg;
		logic dec_pos;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] px_pos_pos;
		logic signed [COORD_W-1:0] py_pos_pos;
		logic signed [COORD_W-1:0] px_neg_neg;
		logic signed [COORD_W-1:0] py_neg_neg;
		logic signed [COORD_W-1:0] px_neg_pos;
		logic signed [COORD_W-1:0] py_neg_pos;
		logic signed [COORD_W-1:0] px_pos_neg;
		logic signed [COORD_W-1:0] py_pos_neg;
		logic                      last_point;
	} pixel_t;

endpackage

@@ design/meg_stream_if.sv @@
interface meg_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/meg_seq.sv @@
`include "midpoint_ellipse_generator_macros.svh"

module meg_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_restart,
	output logic           cmd_ready,
	input  meg_pkg::stat_t stat,
	output meg_pkg::ctrl_t ctrl
);

	meg_pkg::state_t state_q;
	meg_pkg::state_t state_d;
	logic            rst_q;
	logic            active_q;
	logic            r2_q;
	logic            act_set;
	logic            act_clr;
	logic            r2_set;
	logic            r2_clr;
	logic            accept;

	assign accept = cmd_valid && cmd_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			meg_pkg::ST_IDLE: begin
				if (accept && (cmd_restart || active_q)) begin
					state_d = meg_pkg::ST_SQ_RX;
				end
			end
			meg_pkg::ST_SQ_RX: state_d = meg_pkg::ST_SQ_RY;
			meg_pkg::ST_SQ_RY: state_d = rst_q ? meg_pkg::ST_RS_A : meg_pkg::ST_CMP_A;
			meg_pkg::ST_RS_A:  state_d = meg_pkg::ST_RS_B;
			meg_pkg::ST_RS_B:  state_d = meg_pkg::ST_RS_C;
			meg_pkg::ST_RS_C:  state_d = meg_pkg::ST_IDLE;
			meg_pkg::ST_CMP_A: state_d = meg_pkg::ST_CMP_B;
			meg_pkg::ST_CMP_B: state_d = meg_pkg::ST_CMP_C;
			meg_pkg::ST_CMP_C: begin
				priority if (!r2_q && !stat.lt) begin
					state_d = stat.y_neg ? meg_pkg::ST_IDLE : meg_pkg::ST_SW_0;
				end else if (r2_q && stat.y_neg) begin
					state_d = meg_pkg::ST_IDLE;
				end else begin
					state_d = meg_pkg::ST_EMIT;
				end
			end
			meg_pkg::ST_SW_0:  state_d = meg_pkg::ST_SW_1;
			meg_pkg::ST_SW_1:  state_d = meg_pkg::ST_SW_2;
			meg_pkg::ST_SW_2:  state_d = meg_pkg::ST_SW_3;
			meg_pkg::ST_SW_3:  state_d = meg_pkg::ST_SW_4;
			meg_pkg::ST_SW_4:  state_d = meg_pkg::ST_SW_5;
			meg_pkg::ST_SW_5:  state_d = meg_pkg::ST_EMIT;
			meg_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					state_d = meg_pkg::ST_UPD_1;
				end
			end
			meg_pkg::ST_UPD_1: begin
				if (r2_q) begin
					state_d = stat.dec_pos ? meg_pkg::ST_IDLE : meg_pkg::ST_UPD_2;
				end else begin
					state_d = stat.dec_neg ? meg_pkg::ST_IDLE : meg_pkg::ST_UPD_2;
				end
			end
			meg_pkg::ST_UPD_2: state_d = meg_pkg::ST_IDLE;
			default:           state_d = meg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.out_last = r2_q;
		cmd_ready     = 1'b0;
		act_set       = 1'b0;
		act_clr       = 1'b0;
		r2_set        = 1'b0;
		r2_clr        = 1'b0;
		unique case (state_q)
			meg_pkg::ST_IDLE: cmd_ready = 1'b1;
			meg_pkg::ST_SQ_RX: begin
				ctrl.mul_a = meg_pkg::MUL_RX;
				ctrl.mul_b = meg_pkg::MUL_RX;
			end
			meg_pkg::ST_SQ_RY: begin
				ctrl.ld_rx2 = 1'b1;
				ctrl.mul_a  = meg_pkg::MUL_RY;
				ctrl.mul_b  = meg_pkg::MUL_RY;
			end
			meg_pkg::ST_RS_A: begin
				ctrl.ld_ry2  = 1'b1;
				ctrl.mul_a   = meg_pkg::MUL_RX2;
				ctrl.mul_b   = meg_pkg::MUL_RY;
				ctrl.dec_clr = 1'b1;
				ctrl.dec_op  = meg_pkg::DEC_ADD;
				ctrl.dec_src = meg_pkg::SRC_RX2;
			end
			meg_pkg::ST_RS_B: begin
				ctrl.dec_op    = meg_pkg::DEC_SUB;
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X4;
			end
			meg_pkg::ST_RS_C: begin
				ctrl.dec_op    = meg_pkg::DEC_ADD;
				ctrl.dec_src   = meg_pkg::SRC_RY2;
				ctrl.dec_shift = meg_pkg::SH_X4;
				ctrl.x_clr     = 1'b1;
				ctrl.y_ld      = 1'b1;
				act_set        = 1'b1;
				r2_clr         = 1'b1;
			end
			meg_pkg::ST_CMP_A: begin
				ctrl.ld_ry2 = 1'b1;
				ctrl.mul_a  = meg_pkg::MUL_RX2;
				ctrl.mul_b  = meg_pkg::MUL_YABS;
			end
			meg_pkg::ST_CMP_B: begin
				ctrl.ld_t1 = 1'b1;
				ctrl.mul_a = meg_pkg::MUL_RY2;
				ctrl.mul_b = meg_pkg::MUL_XCUR;
			end
			meg_pkg::ST_CMP_C: begin
				if (!r2_q && !stat.lt) begin
					r2_set = 1'b1;
				end
				if ((r2_q || !stat.lt) && stat.y_neg) begin
					act_clr = 1'b1;
				end
			end
			meg_pkg::ST_SW_0: begin
				ctrl.mul_a = meg_pkg::MUL_RX2;
				ctrl.mul_b = meg_pkg::MUL_RY2;
			end
			meg_pkg::ST_SW_1: begin
				ctrl.dec_clr   = 1'b1;
				ctrl.dec_op    = meg_pkg::DEC_SUB;
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X4;
				ctrl.mul_a     = meg_pkg::MUL_X2P1;
				ctrl.mul_b     = meg_pkg::MUL_X2P1;
			end
			meg_pkg::ST_SW_2: begin
				ctrl.mul_a = meg_pkg::MUL_PROD;
				ctrl.mul_b = meg_pkg::MUL_RY2;
			end
			meg_pkg::ST_SW_3: begin
				ctrl.dec_op    = meg_pkg::DEC_ADD;
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X1;
				ctrl.mul_a     = meg_pkg::MUL_YM1ABS;
				ctrl.mul_b     = meg_pkg::MUL_YM1ABS;
			end
			meg_pkg::ST_SW_4: begin
				ctrl.mul_a = meg_pkg::MUL_PROD;
				ctrl.mul_b = meg_pkg::MUL_RX2;
			end
			meg_pkg::ST_SW_5: begin
				ctrl.dec_op    = meg_pkg::DEC_ADD;
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X4;
			end
			meg_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					ctrl.out_ld    = 1'b1;
					ctrl.snap      = 1'b1;
					ctrl.dec_op    = meg_pkg::DEC_ADD;
					ctrl.dec_shift = meg_pkg::SH_X4;
					if (r2_q) begin
						ctrl.mul_a   = meg_pkg::MUL_RX2;
						ctrl.mul_b   = meg_pkg::MUL_YM1ABS;
						ctrl.dec_src = meg_pkg::SRC_RX2;
						ctrl.y_dec   = 1'b1;
					end else begin
						ctrl.mul_a   = meg_pkg::MUL_RY2;
						ctrl.mul_b   = meg_pkg::MUL_XINC;
						ctrl.dec_src = meg_pkg::SRC_RY2;
						ctrl.x_inc   = 1'b1;
					end
				end
			end
			meg_pkg::ST_UPD_1: begin
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X8;
				if (r2_q) begin
					ctrl.dec_op = meg_pkg::DEC_YSIGN;
					if (!stat.dec_pos) begin
						ctrl.mul_a = meg_pkg::MUL_RY2;
						ctrl.mul_b = meg_pkg::MUL_XINC;
						ctrl.x_inc = 1'b1;
					end
					if (stat.y_neg) begin
						act_clr = 1'b1;
					end
				end else begin
					ctrl.dec_op = meg_pkg::DEC_ADD;
					if (!stat.dec_neg) begin
						ctrl.mul_a = meg_pkg::MUL_RX2;
						ctrl.mul_b = meg_pkg::MUL_YM1ABS;
						ctrl.y_dec = 1'b1;
					end
				end
			end
			meg_pkg::ST_UPD_2: begin
				ctrl.dec_src   = meg_pkg::SRC_PROD;
				ctrl.dec_shift = meg_pkg::SH_X8;
				ctrl.dec_op    = r2_q ? meg_pkg::DEC_ADD : meg_pkg::DEC_YSIGN;
			end
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= meg_pkg::ST_IDLE;
			rst_q    <= 1'b0;
			active_q <= 1'b0;
			r2_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rst_q <= cmd_restart;
			end
			if (act_set) begin
				active_q <= 1'b1;
			end else if (act_clr) begin
				active_q <= 1'b0;
			end
			if (r2_set) begin
				r2_q <= 1'b1;
			end else if (r2_clr) begin
				r2_q <= 1'b0;
			end
		end
	end

	`MEG_ASSERT_IMP(a_emit_active, ctrl.out_ld, active_q, "point emitted with no ellipse active")
	`MEG_ASSERT_IMP(a_r2_clear, $fell(r2_q), $past(state_q == meg_pkg::ST_RS_C), "region two left outside a restart")
	`MEG_ASSERT_IMP(a_active_set, $rose(active_q), $past(state_q == meg_pkg::ST_RS_C), "ellipse started outside a restart")
	`MEG_ASSERT_NXT(a_stall_hold, state_q == meg_pkg::ST_EMIT && !stat.out_free, state_q == meg_pkg::ST_EMIT, "point lost while output stalled")

endmodule

@@ design/meg_dp.sv @@
module meg_dp #(
	parameter int RADIUS_BITS = meg_pkg::RADIUS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  meg_pkg::ctrl_t               ctrl,
	output meg_pkg::stat_t               stat,
	input  logic [meg_pkg::CENTER_W-1:0] center_x,
	input  logic [meg_pkg::CENTER_W-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]       radius_x,
	input  logic [RADIUS_BITS-1:0]       radius_y,
	output logic                         out_valid,
	output meg_pkg::pixel_t              out_data,
	input  logic                         out_ready
);

	localparam int MW     = (2 * RADIUS_BITS > 24) ? 2 * RADIUS_BITS : 24;
	localparam int PW     = 2 * MW;
	localparam int SqW    = 2 * RADIUS_BITS;
	localparam int YW     = RADIUS_BITS + 2;
	localparam int XW     = meg_pkg::X_W;
	localparam int DecW   = meg_pkg::DEC_W;
	localparam int CoordW = meg_pkg::COORD_W;

	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          t1_q;
	logic [SqW-1:0]         rx2_q;
	logic [SqW-1:0]         ry2_q;
	logic [DecW-1:0]        dec_q;
	logic [DecW-1:0]        dec_d;
	logic [XW-1:0]          x_q;
	logic signed [YW-1:0]   y_q;
	logic                   dneg_q;
	logic                   dpos_q;
	logic                   out_valid_q;
	meg_pkg::pixel_t        out_q;

	logic [XW-1:0]          x_inc;
	logic [XW:0]            x_2p1;
	logic signed [YW-1:0]   y_m1;
	logic [YW-1:0]          y_abs;
	logic [YW-1:0]          y_m1_abs;
	logic [MW-1:0]          op_a;
	logic [MW-1:0]          op_b;
	logic [DecW-1:0]        dec_opnd;
	logic [DecW-1:0]        dec_term;
	logic [DecW-1:0]        dec_base;
	meg_pkg::pixel_t        pix;

	assign x_inc    = x_q + XW'(1);
	assign x_2p1    = {x_q, 1'b1};
	assign y_m1     = y_q - YW'(1);
	assign y_abs    = y_q[YW-1] ? YW'(-y_q) : YW'(y_q);
	assign y_m1_abs = y_m1[YW-1] ? YW'(-y_m1) : YW'(y_m1);

	function automatic logic [MW-1:0] pick(
		input meg_pkg::mul_sel_t sel,
		input logic [RADIUS_BITS-1:0] rx,
		input logic [RADIUS_BITS-1:0] ry,
		input logic [SqW-1:0] rx2,
		input logic [SqW-1:0] ry2,
		input logic [PW-1:0] prod,
		input logic [XW-1:0] xc,
		input logic [XW-1:0] xi,
		input logic [XW:0] x2,
		input logic [YW-1:0] ya,
		input logic [YW-1:0] ym
	);
		logic [MW-1:0] v;
		unique case (sel)
			meg_pkg::MUL_RX:     v = MW'(rx);
			meg_pkg::MUL_RY:     v = MW'(ry);
			meg_pkg::MUL_RX2:    v = MW'(rx2);
			meg_pkg::MUL_RY2:    v = MW'(ry2);
			meg_pkg::MUL_PROD:   v = prod[MW-1:0];
			meg_pkg::MUL_XCUR:   v = MW'(xc);
			meg_pkg::MUL_XINC:   v = MW'(xi);
			meg_pkg::MUL_X2P1:   v = MW'(x2);
			meg_pkg::MUL_YABS:   v = MW'(ya);
			meg_pkg::MUL_YM1ABS: v = MW'(ym);
			default:             v = '0;
		endcase
		return v;
	endfunction

	assign op_a = pick(ctrl.mul_a, radius_x, radius_y, rx2_q, ry2_q, prod_q,
		x_q, x_inc, x_2p1, y_abs, y_m1_abs);
	assign op_b = pick(ctrl.mul_b, radius_x, radius_y, rx2_q, ry2_q, prod_q,
		x_q, x_inc, x_2p1, y_abs, y_m1_abs);

	always_comb begin
		unique case (ctrl.dec_src)
			meg_pkg::SRC_PROD: dec_opnd = DecW'(prod_q);
			meg_pkg::SRC_RX2:  dec_opnd = DecW'(rx2_q);
			meg_pkg::SRC_RY2:  dec_opnd = DecW'(ry2_q);
			default:           dec_opnd = '0;
		endcase
		dec_term = dec_opnd << ctrl.dec_shift;
		dec_base = ctrl.dec_clr ? '0 : dec_q;
		unique case (ctrl.dec_op)
			meg_pkg::DEC_HOLD:  dec_d = dec_q;
			meg_pkg::DEC_ADD:   dec_d = dec_base + dec_term;
			meg_pkg::DEC_SUB:   dec_d = dec_base - dec_term;
			meg_pkg::DEC_YSIGN: dec_d = y_q[YW-1] ? dec_base + dec_term : dec_base - dec_term;
			default:            dec_d = dec_q;
		endcase
	end

	always_comb begin
		pix.px_pos_pos = CoordW'(center_x) + CoordW'(x_q);
		pix.py_pos_pos = CoordW'(center_y) + CoordW'(y_q);
		pix.px_neg_neg = CoordW'(center_x) - CoordW'(x_q);
		pix.py_neg_neg = CoordW'(center_y) - CoordW'(y_q);
		pix.px_neg_pos = CoordW'(center_x) - CoordW'(x_q);
		pix.py_neg_pos = CoordW'(center_y) + CoordW'(y_q);
		pix.px_pos_neg = CoordW'(center_x) + CoordW'(x_q);
		pix.py_pos_neg = CoordW'(center_y) - CoordW'(y_q);
		pix.last_point = ctrl.out_last && (y_q == '0);
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_q <= PW'(op_a) * PW'(op_b);
		dec_q  <= dec_d;
		if (ctrl.ld_t1) begin
			t1_q <= prod_q;
		end
		if (ctrl.ld_rx2) begin
			rx2_q <= prod_q[SqW-1:0];
		end
		if (ctrl.ld_ry2) begin
			ry2_q <= prod_q[SqW-1:0];
		end
		if (ctrl.snap) begin
			dneg_q <= dec_q[DecW-1];
			dpos_q <= !dec_q[DecW-1] && (dec_q != '0);
		end
		if (ctrl.x_clr) begin
			x_q <= '0;
		end else if (ctrl.x_inc) begin
			x_q <= x_inc;
		end
		if (ctrl.y_ld) begin
			y_q <= YW'(radius_y);
		end else if (ctrl.y_dec) begin
			y_q <= y_m1;
		end
		if (ctrl.out_ld) begin
			out_q <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.lt       = !y_q[YW-1] && (y_q != '0) && (prod_q < t1_q);
	assign stat.y_neg    = y_q[YW-1];
	assign stat.y_zero   = (y_q == '0);
	assign stat.dec_neg  = dneg_q;
	assign stat.dec_pos  = dpos_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/midpoint_ellipse_generator.sv @@
// A step transfer runs the squaring, region test and emit states before its point is registered,
// with the region 2 switch states in between when it crosses; transfers are taken only while idle.
// The pace is set by the single shared multiplier, which every decision term passes through.
// Reset: arst_n clears the sequencer, the ellipse state flags and the output valid at once,
// and loads the configuration registers with their default center and radii.
module midpoint_ellipse_generator #(
	parameter int RADIUS_BITS = meg_pkg::RADIUS_BITS_DEF,
	localparam int CfgW = (RADIUS_BITS > meg_pkg::CENTER_W) ? RADIUS_BITS : meg_pkg::CENTER_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	meg_stream_if.sink                    cmd,
	meg_stream_if.source                  pixel,
	input  logic                          cfg_wr_en,
	input  logic [meg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CfgW-1:0]               cfg_data
);

	localparam int CenterW = meg_pkg::CENTER_W;

	// Configuration registers. They are read directly by the datapath whenever a
	// transfer is being worked on, so a new radius takes effect on the next step.
	logic [CenterW-1:0]     center_x_q;
	logic [CenterW-1:0]     center_y_q;
	logic [RADIUS_BITS-1:0] radius_x_q;
	logic [RADIUS_BITS-1:0] radius_y_q;

	meg_pkg::ctrl_t  ctrl;
	meg_pkg::stat_t  stat;
	logic            cmd_ready;
	logic            out_valid;
	meg_pkg::pixel_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CenterW'(meg_pkg::CENTER_X_RST);
			center_y_q <= CenterW'(meg_pkg::CENTER_Y_RST);
			radius_x_q <= RADIUS_BITS'(meg_pkg::RADIUS_X_RST);
			radius_y_q <= RADIUS_BITS'(meg_pkg::RADIUS_Y_RST);
		end else if (cfg_wr_en) begin
			unique case (meg_pkg::cfg_idx_t'(cfg_index))
				meg_pkg::CFG_CENTER_X: center_x_q <= CenterW'(cfg_data);
				meg_pkg::CFG_CENTER_Y: center_y_q <= CenterW'(cfg_data);
				meg_pkg::CFG_RADIUS_X: radius_x_q <= RADIUS_BITS'(cfg_data);
				meg_pkg::CFG_RADIUS_Y: radius_y_q <= RADIUS_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// The sequencer walks each transfer through a fixed list of multiply and
	// accumulate steps. A restart squares both radii and builds the region 1
	// start term. A step squares the radii, forms both sides of the region test,
	// rebuilds the decision term when the region changes, emits the point into
	// the output register, and then folds in the increments that use the new x
	// and y. The sign of the decision term is sampled before any increment.
	meg_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd.valid),
		.cmd_restart (cmd.data.restart),
		.cmd_ready   (cmd_ready),
		.stat        (stat),
		.ctrl        (ctrl)
	);

	// The datapath holds one registered multiplier, the 48-bit decision
	// accumulator, the current point and a one-entry output register. The input
	// side can take the next transfer while a point still waits in that register;
	// the sequencer only holds back at the emit step until the register frees up.
	meg_dp #(
		.RADIUS_BITS (RADIUS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.radius_x  (radius_x_q),
		.radius_y  (radius_y_q),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_ready (pixel.ready)
	);

	assign cmd.ready   = cmd_ready;
	assign pixel.valid = out_valid;
	assign pixel.data  = out_data;

endmodule
